/* rtl/moving_average_filter_core_defines.svh */
// ----------------------------------------------------------------------------
// moving average filter assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH

`ifndef SYNTH
// condition holds at every edge
`define MAVG_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// same-cycle implication
`define MAVG_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication
`define MAVG_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define MAVG_ASSERT_ALWAYS(lbl, cond, msg)
`define MAVG_ASSERT_IMPL(lbl, pre, post, msg)
`define MAVG_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* rtl/mavg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_pkg
// shared types and constants of the moving average filter
// ----------------------------------------------------------------------------
package mavg_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// window size register
	localparam int           WIN_BITS  = 7;
	localparam logic [6:0]   WIN_RESET = 7'd4;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int KIND_BITS  = 2;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_TAKE    = 2'd0,
		KIND_RESTART = 2'd1,
		KIND_CLEAR   = 2'd2,
		KIND_DROP    = 2'd3
	} item_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_UPDATE,
		BK_START,
		BK_DIV,
		BK_SEND
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

/* rtl/mavg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mavg_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_fifo
// short word queue between the front and the back
// ----------------------------------------------------------------------------
module mavg_fifo #(
	parameter int WIDTH = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      head,
	output mavg_pkg::fifo_status_t status
);
	import mavg_pkg::*;

	`include "moving_average_filter_core_defines.svh"

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);

	`MAVG_ASSERT_IMPL(a_no_push_full, push, !status.full || pop, "word pushed into a full queue")
	`MAVG_ASSERT_IMPL(a_no_pop_empty, pop, !status.empty, "word popped from an empty queue")
	`MAVG_ASSERT_ALWAYS(a_count_in_range, count_q <= CNT_W'(FIFO_DEPTH), "queue count beyond depth")

endmodule

/* rtl/mavg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_front
// accepts input words and sorts them into take, restart, clear or drop
// ----------------------------------------------------------------------------
module mavg_front #(
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [SAMPLE_BITS-1:0]            sample,
	input  logic                                     start_sequence,
	input  logic                                     win_zero,
	input  mavg_pkg::fifo_status_t                   fifo_stat,
	output logic                                     push,
	output logic [mavg_pkg::KIND_BITS+SAMPLE_BITS-1:0] push_data
);
	import mavg_pkg::*;

	item_kind_t kind;

	always_comb begin
		if (win_zero) begin
			// zero window: only the restart flag has any effect
			kind = start_sequence ? KIND_CLEAR : KIND_DROP;
		end else begin
			kind = start_sequence ? KIND_RESTART : KIND_TAKE;
		end
	end

	assign in_stall  = fifo_stat.full;
	assign push      = in_valid && !fifo_stat.full && (kind != KIND_DROP);
	assign push_data = {kind, sample};

endmodule

/* rtl/mavg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mavg_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_shift;
	logic [DEN_W:0]   rem_trial;
	logic             fits;

	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign rem_trial = rem_shift - {1'b0, den_q};
	assign fits      = (rem_shift >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			// quotient bits shift in where dividend bits shift out
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? rem_trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;

endmodule

/* rtl/mavg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_back
// window update, running sum, division and result register
// ----------------------------------------------------------------------------
module mavg_back #(
	parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]            eff_win,
	input  logic                                       win_clear,
	input  logic [mavg_pkg::KIND_BITS+SAMPLE_BITS-1:0] head,
	input  mavg_pkg::fifo_status_t                     fifo_stat,
	output logic                                       pop,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [SAMPLE_BITS-1:0]              average
);
	import mavg_pkg::*;

	`include "moving_average_filter_core_defines.svh"

	localparam int EW_BITS = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W   = $clog2(MAX_WINDOW);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int IX_W    = EW_BITS + 1;
	localparam int EXT_W   = SUM_W - SAMPLE_BITS;

	back_state_t state_q;
	back_state_t state_d;

	item_kind_t                    head_kind;
	logic [SAMPLE_BITS-1:0]        head_sample;
	logic [SAMPLE_BITS-1:0]        sample_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [EW_BITS-1:0]            fill_q;
	logic [PTR_W-1:0]              wptr_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        average_q;

	logic                          ram_re;
	logic                          ram_we;
	logic [SAMPLE_BITS-1:0]        old_sample;
	logic [IX_W-1:0]               wp_x;
	logic [IX_W-1:0]               win_x;
	logic [IX_W-1:0]               old_x;
	logic [PTR_W-1:0]              old_idx;
	logic                          full;
	logic                          produce;
	logic signed [SUM_W-1:0]       sum_next;
	logic [SUM_W-1:0]              sum_mag;
	logic                          out_free;
	logic                          div_start;
	logic                          div_busy;
	logic [SUM_W-1:0]              div_quo;
	logic [SAMPLE_BITS-1:0]        quo_low;
	logic                          load_out;

	assign head_kind   = item_kind_t'(head[KIND_BITS+SAMPLE_BITS-1:SAMPLE_BITS]);
	assign head_sample = head[SAMPLE_BITS-1:0];

	// slot of the sample leaving the window
	assign wp_x    = IX_W'(wptr_q);
	assign win_x   = IX_W'(eff_win);
	assign old_x   = (wp_x >= win_x) ? (wp_x - win_x) : (wp_x + IX_W'(MAX_WINDOW) - win_x);
	assign old_idx = old_x[PTR_W-1:0];

	assign full     = (fill_q >= eff_win);
	assign produce  = full || ((fill_q + EW_BITS'(1)) == eff_win);
	assign sum_next = sum_q
		- (full ? {{EXT_W{old_sample[SAMPLE_BITS-1]}}, old_sample} : '0)
		+ {{EXT_W{sample_q[SAMPLE_BITS-1]}}, sample_q};
	assign sum_mag  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign out_free = !out_valid_q || !out_stall;
	assign quo_low  = div_quo[SAMPLE_BITS-1:0];

	mavg_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q),
		.wdata(sample_q),
		.re   (ram_re),
		.raddr(old_idx),
		.rdata(old_sample)
	);

	mavg_div #(
		.NUM_W(SUM_W),
		.DEN_W(EW_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_mag),
		.den   (eff_win),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_stat.empty && head_kind != KIND_CLEAR) begin
					state_d = BK_READ;
				end
			end
			BK_READ:   state_d = BK_UPDATE;
			BK_UPDATE: state_d = produce ? BK_START : BK_IDLE;
			BK_START:  state_d = BK_DIV;
			BK_DIV: begin
				if (!div_busy) begin
					state_d = BK_SEND;
				end
			end
			BK_SEND: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			BK_IDLE:   pop       = !fifo_stat.empty;
			BK_READ:   ram_re    = 1'b1;
			BK_UPDATE: ram_we    = 1'b1;
			BK_START:  div_start = 1'b1;
			BK_SEND:   load_out  = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= head_sample;
		end
		if (load_out) begin
			average_q <= sum_q[SUM_W-1] ? (~quo_low + 1'b1) : quo_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			sum_q       <= '0;
			fill_q      <= '0;
			wptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (win_clear || (pop && (head_kind == KIND_RESTART || head_kind == KIND_CLEAR))) begin
				sum_q  <= '0;
				fill_q <= '0;
				wptr_q <= '0;
			end else if (state_q == BK_UPDATE) begin
				sum_q  <= sum_next;
				wptr_q <= (wptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wptr_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

	`MAVG_ASSERT_ALWAYS(a_fill_in_window, fill_q <= eff_win, "fill count beyond window size")
	`MAVG_ASSERT_IMPL(a_div_free_on_start, div_start, !div_busy, "divider started while busy")
	`MAVG_ASSERT_NEXT(a_ring_read_then_write, state_q == BK_READ, state_q == BK_UPDATE,
		"ring read not followed by the window update")

endmodule

/* rtl/moving_average_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter_core
// sliding boxcar average of signed fixed-point samples
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with sample and start_sequence; a word
// with start_sequence high empties the window before its sample is taken.
// output channel: out_valid / out_stall with average, the window sum over the
// window size, truncated toward zero. no word comes out until the window has
// filled; from then on each input word gives one average.
// cfg_wr_en / cfg_wr_data set the window size (reset 4, sizes above
// MAX_WINDOW act as MAX_WINDOW, zero stops all results) and empty the window.
// each word passes the back end states idle, read, update, start, div and
// send; the divider makes one quotient bit per cycle, and a word that gives
// no result goes back to idle after update. the back end takes one word at a
// time and does not take the next until it is done with the last.
// a two-word queue keeps in_stall low while the back end is busy until it
// fills; a stalled result waits in the output register while the next word
// is already being worked on.
// reset clears the window, the queue and the output valid flag at once.
// ----------------------------------------------------------------------------
module moving_average_filter_core #(
	parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [mavg_pkg::WIN_BITS-1:0]   cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            start_sequence,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [SAMPLE_BITS-1:0]   average
);
	import mavg_pkg::*;

	localparam int EW_BITS = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W   = (WIN_BITS > EW_BITS) ? WIN_BITS : EW_BITS;
	localparam int WORD_W  = KIND_BITS + SAMPLE_BITS;

	logic [WIN_BITS-1:0] win_q;
	logic [CMP_W-1:0]    win_ext;
	logic [EW_BITS-1:0]  eff_win;
	fifo_status_t        fifo_stat;
	logic                push;
	logic                pop;
	logic [WORD_W-1:0]   push_data;
	logic [WORD_W-1:0]   head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			win_q <= cfg_wr_data;
		end
	end

	// window size saturates at the ring depth
	assign win_ext = CMP_W'(win_q);
	assign eff_win = (win_ext > CMP_W'(MAX_WINDOW)) ? EW_BITS'(MAX_WINDOW)
		: win_ext[EW_BITS-1:0];

	mavg_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.start_sequence(start_sequence),
		.win_zero      (eff_win == '0),
		.fifo_stat     (fifo_stat),
		.push          (push),
		.push_data     (push_data)
	);

	mavg_fifo #(
		.WIDTH(WORD_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.status   (fifo_stat)
	);

	mavg_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_win  (eff_win),
		.win_clear(cfg_wr_en),
		.head     (head),
		.fifo_stat(fifo_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average  (average)
	);

endmodule

/* sim/tb_moving_average_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_filter_core
// self-checking bench for the boxcar moving average filter
// ----------------------------------------------------------------------------
// a directed table (extremes, truncation toward zero, restart inside a full
// window) runs at the reset window size, then random phases run through window
// sizes from zero to oversized under different idle and stall patterns. every
// accepted word goes through a local model of the window; each average that
// comes out is compared with the oldest pending one.
// ----------------------------------------------------------------------------
module tb_moving_average_filter_core;

	import mavg_pkg::*;

	localparam int SMP_W  = SAMPLE_BITS_DEF;
	localparam int HIST_N = MAX_WINDOW_DEF;
	localparam int N_PH   = 10;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [SMP_W-1:0] smp;
		bit                      seq;
		bit                      fixed;
		logic signed [SMP_W-1:0] want;
	} dir_row_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     cfg_wr_en      = 1'b0;
	logic [WIN_BITS-1:0]      cfg_wr_data    = '0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic signed [SMP_W-1:0]  sample         = '0;
	logic                     start_sequence = 1'b0;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic signed [SMP_W-1:0]  average;

	// window model
	logic signed [SMP_W-1:0]  hist [HIST_N];
	int                       hist_sum;
	int                       hist_fill;
	int                       hist_wp;
	int                       win_len;

	logic signed [SMP_W-1:0]  avg_due [$];
	int                       send_idle_pct = 0;
	int                       recv_stall_pct = 0;
	int                       n_err = 0;
	int                       words_sent = 0;
	int                       avgs_checked = 0;
	bit                       out_fire = 1'b0;
	logic signed [SMP_W-1:0]  out_word;

	// window size 4 from reset
	dir_row_t dir_rows [23] = '{
		'{16'sh7fff, 1'b1, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b0, 16'sh0000},
		'{16'sh7fff, 1'b0, 1'b1, 16'sh7fff},
		'{16'sh7fff, 1'b0, 1'b1, 16'sh7fff},
		'{16'sh8000, 1'b1, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh8000, 1'b0, 1'b1, 16'sh8000},
		'{16'sh0001, 1'b1, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0000, 1'b0, 1'b1, 16'sh0000},
		// negative sums truncate toward zero
		'{16'shffff, 1'b0, 1'b1, 16'sh0000},
		'{16'shffff, 1'b0, 1'b1, 16'sh0000},
		'{16'shffff, 1'b0, 1'b1, 16'sh0000},
		'{16'shffff, 1'b0, 1'b1, 16'shffff},
		'{16'sh5555, 1'b1, 1'b0, 16'sh0000},
		'{16'shaaaa, 1'b0, 1'b0, 16'sh0000},
		'{16'sh0007, 1'b0, 1'b0, 16'sh0000},
		'{16'shfff9, 1'b0, 1'b0, 16'sh0000},
		'{16'sh1234, 1'b0, 1'b0, 16'sh0000},
		// restart inside a full window
		'{16'sh8000, 1'b1, 1'b0, 16'sh0000}
	};

	int         ph_win  [N_PH] = '{1, 64, 0, 127, 3, 7, 2, 5, 65, 16};
	int         ph_len  [N_PH] = '{40, 100, 10, 70, 30, 30, 30, 30, 30, 30};
	idle_mode_t ph_mode [N_PH] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
		IDLE_RECV, IDLE_SEND, IDLE_BOTH, IDLE_NONE, IDLE_RECV};

	moving_average_filter_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.start_sequence(start_sequence),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.average       (average)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAIL moving_average_filter_core");
		$finish;
	end

	function automatic int eff_window();
		return (win_len > HIST_N) ? HIST_N : win_len;
	endfunction

	task automatic clear_window();
		hist_sum  = 0;
		hist_fill = 0;
		hist_wp   = 0;
	endtask

	// advance the window by one word, returns whether an average is due
	task automatic window_step(input logic signed [SMP_W-1:0] s, input bit seq,
			output bit gives, output logic signed [SMP_W-1:0] avg);
		int eff;
		int oldest;
		gives = 1'b0;
		avg   = '0;
		if (seq)
			clear_window();
		eff = eff_window();
		if (eff == 0)
			return;
		if (hist_fill >= eff) begin
			oldest = (hist_wp + HIST_N - eff) % HIST_N;
			hist_sum -= hist[oldest];
		end else begin
			hist_fill++;
		end
		hist[hist_wp] = s;
		hist_sum += s;
		hist_wp = (hist_wp + 1) % HIST_N;
		if (hist_fill < eff)
			return;
		gives = 1'b1;
		avg   = SMP_W'(hist_sum / eff);
	endtask

	function automatic logic signed [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SMP_W'(int'($urandom_range(0, 15)) - 8);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic void set_idle(input idle_mode_t m);
		send_idle_pct  = (m == IDLE_SEND) ? 82 : (m == IDLE_BOTH) ? 14 : 0;
		recv_stall_pct = (m == IDLE_RECV) ? 82 : (m == IDLE_BOTH) ? 14 : 0;
	endfunction

	// present one word, return in the step of its acceptance
	task automatic put_word(input logic signed [SMP_W-1:0] s, input bit seq, input bit fixed,
			input logic signed [SMP_W-1:0] want);
		bit acc;
		bit gives;
		logic signed [SMP_W-1:0] avg;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		sample         <= s;
		start_sequence <= seq;
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
		window_step(s, seq, gives, avg);
		if (gives)
			avg_due.insert(avg_due.size(), fixed ? want : avg);
		words_sent++;
	endtask

	// called in an acceptance step: valid drops once, then wait for the averages
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (avg_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input int w);
		drain();
		// words that give no average may still be in the back end
		repeat (40) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= WIN_BITS'(w);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		win_len = w;
		clear_window();
	endtask

	// output side sampled mid-cycle, checked at the edge that takes the word
	always @(negedge clk) begin
		out_fire = arst_n && out_valid && !out_stall;
		out_word = average;
	end

	always @(posedge clk) begin
		if (out_fire) begin
			if (avg_due.size() == 0) begin
				$display("%0t: unexpected average %0d, expected none", $time, out_word);
				n_err++;
			end else begin
				if (out_word !== avg_due[0]) begin
					$display("%0t: average mismatch, expected %0d got %0d",
						$time, avg_due[0], out_word);
					n_err++;
				end
				void'(avg_due.pop_front());
				avgs_checked++;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		int eff;
		win_len = WIN_RESET;
		clear_window();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(IDLE_NONE);
		foreach (dir_rows[i])
			put_word(dir_rows[i].smp, dir_rows[i].seq, dir_rows[i].fixed, dir_rows[i].want);

		for (int p = 0; p < N_PH; p++) begin
			write_window(ph_win[p]);
			set_idle(ph_mode[p]);
			eff = eff_window();
			for (int i = 0; i < ph_len[p]; i++) begin
				if (i == ph_len[p] / 2)
					drain();
				put_word(pick_sample(), $urandom_range(0, 4 * eff + 20) == 0, 1'b0, '0);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("run covered %0d input words and %0d averages, window sizes 0 to 127",
			words_sent, avgs_checked);
		$display("with restarts, sender gaps, receiver stalls and mid-run drains");
		if (n_err == 0)
			$display("PASS moving_average_filter_core");
		else
			$display("FAIL moving_average_filter_core");
		$finish;
	end

endmodule
